// ===== sv/centered_moving_average_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the centered moving average core
// Shared helpers for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef CENTERED_MOVING_AVERAGE_CORE_DEFINES_SVH
`define CENTERED_MOVING_AVERAGE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CMA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define CMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/cma_pkg.sv =====
// ----------------------------------------------------------------------------
// cma_pkg
// Types and constants shared by the centered moving average modules.
// ----------------------------------------------------------------------------
package cma_pkg;

  // Smallest window the core will run.
  localparam int MIN_WIDTH = 3;

  // Commands from the sequencer to the accumulate / divide unit.
  typedef struct packed {
    logic clr;        // zero the accumulator
    logic add;        // add the memory read data
    logic div_start;  // start dividing the accumulator by the width
  } cma_ctl_t;

  // Status back from the accumulate / divide unit.
  typedef struct packed {
    logic busy;       // division in progress
  } cma_sts_t;

endpackage

// ===== sv/cma_window_mem.sv =====
// ----------------------------------------------------------------------------
// cma_window_mem
// Sample history memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cma_window_mem #(
  parameter int DEPTH = 64,
  parameter int AB    = 6,
  parameter int DB    = 16
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AB-1:0] wr_addr,
  input  logic [DB-1:0] wr_data,
  input  logic [AB-1:0] rd_addr,
  output logic [DB-1:0] rd_data
);

  logic [DB-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/cma_accum_div.sv =====
// ----------------------------------------------------------------------------
// cma_accum_div
// Shared arithmetic unit: window accumulator plus a restoring divider that
// retires one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module cma_accum_div #(
  parameter int DB = 16,  // sample bits
  parameter int PB = 6    // width / index bits
) (
  input  logic              clk,
  input  logic              rst,
  input  cma_pkg::cma_ctl_t ctl,
  input  logic [DB-1:0]     rd_data,
  input  logic [PB-1:0]     width,
  output cma_pkg::cma_sts_t sts,
  output logic [DB-1:0]     quotient
);

  import cma_pkg::*;

  localparam int SB = DB + PB;
  localparam int CB = $clog2(SB);

  logic signed [SB-1:0] acc;
  logic        [SB-1:0] dvd;      // dividend magnitude, quotient shifts in
  logic        [PB-1:0] rem;
  logic        [CB-1:0] cnt;
  logic                 neg;
  logic                 busy;

  logic        [PB:0]   rem_sh;
  logic                 q_bit;
  logic        [PB:0]   rem_sub;
  logic        [SB-1:0] q_signed;

  assign rem_sh  = {rem, dvd[SB-1]};
  assign q_bit   = (rem_sh >= {1'b0, width});
  assign rem_sub = rem_sh - {1'b0, width};

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc <= '0;
    end else if (ctl.add) begin
      acc <= acc + {{PB{rd_data[DB-1]}}, rd_data};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ctl.div_start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CB'(SB - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.div_start) begin
      neg <= acc[SB-1];
      dvd <= acc[SB-1] ? SB'(-acc) : SB'(acc);
      rem <= '0;
    end else if (busy) begin
      rem <= q_bit ? rem_sub[PB-1:0] : rem_sh[PB-1:0];
      dvd <= {dvd[SB-2:0], q_bit};
    end
  end

  assign q_signed   = neg ? (~dvd + 1'b1) : dvd;
  assign quotient   = q_signed[DB-1:0];
  assign sts.busy   = busy;

endmodule

// ===== sv/centered_moving_average_core.sv =====
// ----------------------------------------------------------------------------
// centered_moving_average_core
// Centered boxcar filter over a finite, zero padded signal.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    tdata: sample; tlast: last sample
// m_*       out  m_tvalid/m_tready    tdata: average; tlast: last result
// cfg_*     in   cfg_valid/cfg_ready  cfg_data: requested width
//
// Each item is accepted and decided on, then yields 0, 1 or up to H+1 averages,
// each built in order: a setup step, reads over the single port, closing the sum,
// the serial divider and loading the output register. Reset clears the
// sequencer, sample count and output valid; history reads past the sample count
// are masked to zero. A stalled output holds the emit step.
// ----------------------------------------------------------------------------
module centered_moving_average_core #(
  parameter int MAX_WIDTH   = 63,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // input items
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,   // [SAMPLE_BITS-1:0] sample
  input  logic                                s_tlast,   // last sample
  // result items
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,   // [SAMPLE_BITS-1:0] average
  output logic                                m_tlast,   // last result
  // width register
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [5:0]                          cfg_data
);

  import cma_pkg::*;

  localparam int DB     = SAMPLE_BITS;
  localparam int TDW    = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int DEPTH  = MAX_WIDTH + 1;
  localparam int PB     = $clog2(DEPTH);
  localparam int MAXODD = (MAX_WIDTH % 2 == 1) ? MAX_WIDTH : MAX_WIDTH - 1;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECIDE = 8'b0000_0010,
    S_PREP   = 8'b0000_0100,
    S_SUM    = 8'b0000_1000,
    S_DRAIN  = 8'b0001_0000,
    S_START  = 8'b0010_0000,
    S_DIV    = 8'b0100_0000,
    S_EMIT   = 8'b1000_0000
  } state_t;

  state_t        state;
  logic [5:0]    req_width;
  logic [PB-1:0] wp;        // next free slot
  logic [PB-1:0] rp;        // read pointer, walks from newest to oldest
  logic [PB-1:0] seen;      // samples of this signal, saturating
  logic [PB-1:0] d;         // center offset of the current average
  logic [PB-1:0] k;         // tap index within the window
  logic          last_q;
  logic          in_flush;
  logic          rd_live;   // registered: read data belongs to the window

  // effective width
  logic [6:0]    w_round;
  logic [PB-1:0] w;
  logic [PB-1:0] h;
  logic [PB-1:0] sum_end;
  logic [PB-1:0] newest;

  cma_ctl_t      ctl;
  cma_sts_t      sts;
  logic [DB-1:0] rd_data;
  logic [DB-1:0] quotient;
  logic          out_free;
  logic          final_out;

  always_comb begin
    if (req_width < 6'(MIN_WIDTH)) begin
      w_round = 7'(MIN_WIDTH);
    end else if (!req_width[0]) begin
      w_round = {1'b0, req_width} + 7'd1;
    end else begin
      w_round = {1'b0, req_width};
    end
  end

  assign w       = (32'(w_round) > 32'(MAX_WIDTH)) ? PB'(MAXODD) : PB'(w_round);
  assign h       = w >> 1;
  assign sum_end = d + h;
  assign newest  = (wp == '0) ? PB'(MAX_WIDTH) : wp - 1'b1;

  // nothing is taken while reset is held
  assign s_tready  = (state == S_IDLE) && !rst;
  assign cfg_ready = !rst;
  assign out_free  = !m_tvalid || m_tready;
  assign final_out = in_flush && (d == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      req_width <= 6'(MIN_WIDTH);
    end else if (cfg_valid && cfg_ready) begin
      req_width <= cfg_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      wp       <= '0;
      seen     <= '0;
      in_flush <= 1'b0;
      m_tvalid <= 1'b0;
      rd_live  <= 1'b0;
    end else begin
      rd_live <= (state == S_SUM) && (k < seen);
      // the emit step reloads the output register itself
      if (m_tvalid && m_tready && (state != S_EMIT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            wp     <= (wp == PB'(MAX_WIDTH)) ? '0 : wp + 1'b1;
            seen   <= (seen == PB'(MAX_WIDTH)) ? seen : seen + 1'b1;
            last_q <= s_tlast;
            state  <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (seen > h) begin
            d        <= h;
            in_flush <= 1'b0;
            state    <= S_PREP;
          end else if (last_q) begin
            // short signal: one average per sample received
            d        <= seen - 1'b1;
            in_flush <= 1'b1;
            state    <= S_PREP;
          end else begin
            state <= S_IDLE;
          end
        end
        S_PREP: begin
          k     <= '0;
          rp    <= newest;
          state <= S_SUM;
        end
        S_SUM: begin
          if (k == sum_end) begin
            state <= S_DRAIN;
          end else begin
            k  <= k + 1'b1;
            rp <= (rp == '0) ? PB'(MAX_WIDTH) : rp - 1'b1;
          end
        end
        S_DRAIN: begin
          state <= S_START;
        end
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (!sts.busy) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= TDW'(quotient);
            m_tlast  <= final_out;
            if (!in_flush) begin
              if (last_q) begin
                d        <= ((seen < h) ? seen : h) - 1'b1;
                in_flush <= 1'b1;
                state    <= S_PREP;
              end else begin
                state <= S_IDLE;
              end
            end else if (d != '0) begin
              d     <= d - 1'b1;
              state <= S_PREP;
            end else begin
              // end of signal: drop the history
              seen     <= '0;
              in_flush <= 1'b0;
              state    <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign ctl.clr       = (state == S_PREP);
  assign ctl.add       = rd_live;
  assign ctl.div_start = (state == S_START);

  cma_window_mem #(
    .DEPTH (DEPTH),
    .AB    (PB),
    .DB    (DB)
  ) u_mem (
    .clk     (clk),
    .wr_en   (s_tvalid && s_tready),
    .wr_addr (wp),
    .wr_data (s_tdata[DB-1:0]),
    .rd_addr (rp),
    .rd_data (rd_data)
  );

  cma_accum_div #(
    .DB (DB),
    .PB (PB)
  ) u_alu (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .rd_data  (rd_data),
    .width    (w),
    .sts      (sts),
    .quotient (quotient)
  );

`include "centered_moving_average_core_defines.svh"

  `CMA_ASSERT_NOW(a_no_accept_in_flush, s_tready, !in_flush, "input taken during flush")
  `CMA_ASSERT_NOW(a_tap_in_window, state == S_SUM, k <= sum_end, "tap past window end")
  `CMA_ASSERT_NEXT(a_final_clears, state == S_EMIT && out_free && final_out,
                   state == S_IDLE && seen == '0 && m_tlast, "final result left state")

endmodule
